// ----- sv/slm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the similar line merger.
// No dependencies; every other file of the block imports this package.
package slm_pkg;

    localparam int DATA_W        = 16;
    localparam int SIZE_W        = 7;
    localparam int SUM_W         = 22;
    localparam int MAX_LINES_DEF = 64;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] REG_DIST_TOL  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_TOL = 1'b1;

    // One stored line as it travels along the chain.
    typedef struct packed {
        logic                     alive;
        logic                     proc;
        logic                     first;
        logic [SIZE_W-1:0]        size;
        logic signed [DATA_W-1:0] distance;
        logic [DATA_W-1:0]        ang;
    } cell_t;

endpackage

// ----- sv/slm_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for line input words and merged output words.
// Depends on slm_pkg for field widths.
interface line_in_if;
    import slm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] line_distance;
    logic [DATA_W-1:0]        line_angle;
    logic                     final_line;

    modport source (output valid, line_distance, line_angle, final_line, input ready);
    modport sink   (input valid, line_distance, line_angle, final_line, output ready);
endinterface

interface merged_out_if;
    import slm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] merged_distance;
    logic [DATA_W-1:0]        merged_angle;
    logic [SIZE_W-1:0]        group_size;
    logic                     end_of_list;
    logic                     lines_dropped;

    modport source (output valid, merged_distance, merged_angle, group_size, end_of_list,
                    lines_dropped, input ready);
    modport sink   (input valid, merged_distance, merged_angle, group_size, end_of_list,
                    lines_dropped, output ready);
endinterface

// ----- sv/slm_cell.sv -----
`timescale 1ns / 1ps
// One storage cell of the rotating line chain.
// Depends on slm_pkg for cell_t.
module slm_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift_en,
    input  slm_pkg::cell_t from_next,
    output slm_pkg::cell_t value
);
    import slm_pkg::*;

    cell_t cell_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (shift_en)
        begin
            cell_reg <= from_next;
        end
    end

    assign value = cell_reg;

endmodule

// ----- sv/slm_div.sv -----
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on slm_pkg for widths.
module slm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [slm_pkg::SUM_W-1:0]  dividend,
    input  logic [slm_pkg::SIZE_W-1:0] divisor,
    output logic                       done,
    output logic [slm_pkg::DATA_W-1:0] quotient
);
    import slm_pkg::*;

    localparam int CW = $clog2(SUM_W + 1);

    logic [SIZE_W-1:0] rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [SIZE_W-1:0] div_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [SIZE_W:0]   trial;
    logic              bit_next;
    logic [SIZE_W:0]   rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[SUM_W-1]};
        bit_next = (trial >= {1'b0, div_reg});
        rem_next = bit_next ? (trial - {1'b0, div_reg}) : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next[SIZE_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], bit_next};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[DATA_W-1:0];

endmodule

// ----- sv/similar_line_merger_core.sv -----
`timescale 1ns / 1ps
// Similar line merger: a rotating chain of MAX_LINES cells, compared at the head cell.
// Lines are loaded into the tail of the chain. After the final line, each survivor is
// compared against every other cell in turn, then divided and written back; dead or empty
// cells are passed over, a final lap finds no further survivor, the chain rotates to the
// first line, and the survivors are emitted, subject to output stalls.
// Reset is asynchronous and active low; it empties the chain and loads default tolerances.
module similar_line_merger_core #(
    parameter int MAX_LINES = slm_pkg::MAX_LINES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [slm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [slm_pkg::DATA_W-1:0]    cfg_data,
    line_in_if.sink                       line_in,
    merged_out_if.source                  merged_out
);
    import slm_pkg::*;

    localparam int CNT_W = $clog2(MAX_LINES + 1);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_MERGE = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_SEEK  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     ovf_reg, ovf_next;
    logic [DATA_W-1:0]        dtol_reg, atol_reg;
    logic signed [DATA_W-1:0] sel_d_reg, sel_d_next;
    logic [DATA_W-1:0]        sel_a_reg, sel_a_next;
    logic                     sel_act_reg, sel_act_next;
    logic [SUM_W-1:0]         dsum_reg, dsum_next;
    logic [SUM_W-1:0]         asum_reg, asum_next;
    logic [SIZE_W-1:0]        m_reg, m_next;
    logic [CNT_W-1:0]         step_reg, step_next;
    logic [CNT_W-1:0]         idle_reg, idle_next;
    logic [CNT_W-1:0]         surv_reg, surv_next;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_d_reg;
    logic [DATA_W-1:0]        out_a_reg;
    logic [SIZE_W-1:0]        out_size_reg;
    logic                     out_last_reg, out_last_next;
    logic                     out_drop_reg;
    logic                     out_load;

    cell_t                    cells [MAX_LINES];
    cell_t                    tail_d;
    cell_t                    head;
    logic                     shift_en;

    logic                     in_acc;
    logic                     can_go;
    logic                     head_free;
    logic signed [DATA_W:0]   dd;
    logic [DATA_W:0]          dabs;
    logic [DATA_W-1:0]        da;
    logic                     match;
    logic [SUM_W-1:0]         head_dsx;
    logic [SUM_W-1:0]         head_asx;

    logic                     div_start;
    logic                     dsum_neg;
    logic [SUM_W-1:0]         dmag;
    logic                     ddone, adone;
    logic [DATA_W-1:0]        dq, aq;
    logic signed [DATA_W-1:0] dres;
    logic                     dneg_reg;

    genvar k;
    generate
        for (k = 0; k < MAX_LINES; k++)
        begin : g_cell
            if (k == MAX_LINES - 1)
            begin : g_tail
                slm_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift_en  (shift_en),
                    .from_next (tail_d),
                    .value     (cells[k])
                );
            end
            else
            begin : g_body
                slm_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift_en  (shift_en),
                    .from_next (cells[k+1]),
                    .value     (cells[k])
                );
            end
        end
    endgenerate

    assign head      = cells[0];
    assign head_free = head.alive && !head.proc;
    assign in_acc    = line_in.valid && line_in.ready;
    assign can_go    = !out_valid_reg || merged_out.ready;
    assign head_dsx  = {{(SUM_W-DATA_W){head.distance[DATA_W-1]}}, head.distance};
    assign head_asx  = {{(SUM_W-DATA_W){1'b0}}, head.ang};

    // Differences are always taken against the selected line's loaded values.
    always_comb
    begin
        dd    = {sel_d_reg[DATA_W-1], sel_d_reg} - {head.distance[DATA_W-1], head.distance};
        dabs  = dd[DATA_W] ? (DATA_W+1)'(-dd) : dd;
        da    = (sel_a_reg > head.ang) ? (sel_a_reg - head.ang) : (head.ang - sel_a_reg);
        match = (dabs < {1'b0, dtol_reg}) && (da < atol_reg);
    end

    // Distance is divided as a magnitude so the quotient truncates toward zero.
    assign dsum_neg = dsum_reg[SUM_W-1];
    assign dmag     = dsum_neg ? (SUM_W)'(-dsum_reg) : dsum_reg;
    assign dres     = dneg_reg ? DATA_W'(-dq) : dq;

    slm_div u_div_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dmag),
        .divisor  (m_reg),
        .done     (ddone),
        .quotient (dq)
    );

    slm_div u_div_ang (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (asum_reg),
        .divisor  (m_reg),
        .done     (adone),
        .quotient (aq)
    );

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        sel_d_next    = sel_d_reg;
        sel_a_next    = sel_a_reg;
        sel_act_next  = sel_act_reg;
        dsum_next     = dsum_reg;
        asum_next     = asum_reg;
        m_next        = m_reg;
        step_next     = step_reg;
        idle_next     = idle_reg;
        surv_next     = surv_reg;
        out_load      = 1'b0;
        out_last_next = out_last_reg;
        div_start     = 1'b0;
        shift_en      = 1'b0;
        tail_d        = head;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (cnt_reg < CNT_W'(MAX_LINES))
                    begin
                        shift_en        = 1'b1;
                        tail_d.alive    = 1'b1;
                        tail_d.proc     = 1'b0;
                        tail_d.first    = (cnt_reg == '0);
                        tail_d.size     = SIZE_W'(1);
                        tail_d.distance = line_in.line_distance;
                        tail_d.ang      = line_in.line_angle;
                        cnt_next        = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (line_in.final_line)
                    begin
                        state_next   = ST_MERGE;
                        sel_act_next = 1'b0;
                        idle_next    = '0;
                        surv_next    = '0;
                    end
                end
            end
            ST_MERGE:
            begin
                if (sel_act_reg)
                begin
                    if (step_reg == CNT_W'(MAX_LINES))
                    begin
                        // The selected line is back at the head cell.
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        shift_en  = 1'b1;
                        step_next = step_reg + 1'b1;
                        if (head_free && match)
                        begin
                            tail_d.alive = 1'b0;
                            dsum_next    = dsum_reg + head_dsx;
                            asum_next    = asum_reg + head_asx;
                            m_next       = m_reg + 1'b1;
                        end
                    end
                end
                else if (head_free)
                begin
                    shift_en     = 1'b1;
                    tail_d.proc  = 1'b1;
                    sel_d_next   = head.distance;
                    sel_a_next   = head.ang;
                    dsum_next    = head_dsx;
                    asum_next    = head_asx;
                    m_next       = SIZE_W'(1);
                    step_next    = CNT_W'(1);
                    sel_act_next = 1'b1;
                    surv_next    = surv_reg + 1'b1;
                end
                else if (idle_reg == CNT_W'(MAX_LINES))
                begin
                    state_next = ST_SEEK;
                end
                else
                begin
                    shift_en  = 1'b1;
                    idle_next = idle_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                if (ddone && adone)
                begin
                    shift_en        = 1'b1;
                    tail_d.distance = dres;
                    tail_d.ang      = aq;
                    tail_d.size     = m_reg;
                    sel_act_next    = 1'b0;
                    idle_next       = '0;
                    state_next      = ST_MERGE;
                end
            end
            ST_SEEK:
            begin
                if (head.first)
                begin
                    state_next = ST_EMIT;
                    step_next  = '0;
                end
                else
                begin
                    shift_en = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (step_reg == CNT_W'(MAX_LINES))
                begin
                    state_next = ST_LOAD;
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                end
                else if (!head.alive || can_go)
                begin
                    // Each cell is cleared as it passes, leaving the chain empty.
                    shift_en  = 1'b1;
                    tail_d    = '0;
                    step_next = step_reg + 1'b1;
                    if (head.alive)
                    begin
                        out_load      = 1'b1;
                        out_last_next = (surv_reg == CNT_W'(1));
                        surv_next     = surv_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            sel_act_reg   <= 1'b0;
            step_reg      <= '0;
            idle_reg      <= '0;
            surv_reg      <= '0;
            out_valid_reg <= 1'b0;
            dtol_reg      <= DATA_W'(144);
            atol_reg      <= DATA_W'(5461);
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            sel_act_reg <= sel_act_next;
            step_reg    <= step_next;
            idle_reg    <= idle_next;
            surv_reg    <= surv_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (merged_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_DIST_TOL)
                begin
                    dtol_reg <= cfg_data;
                end
                else if (cfg_index == REG_ANGLE_TOL)
                begin
                    atol_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sel_d_reg <= sel_d_next;
        sel_a_reg <= sel_a_next;
        dsum_reg  <= dsum_next;
        asum_reg  <= asum_next;
        m_reg     <= m_next;
        if (div_start)
        begin
            dneg_reg <= dsum_neg;
        end
        if (out_load)
        begin
            out_d_reg    <= head.distance;
            out_a_reg    <= head.ang;
            out_size_reg <= head.size;
            out_last_reg <= out_last_next;
            out_drop_reg <= ovf_reg;
        end
    end

    assign line_in.ready              = (state_reg == ST_LOAD);
    assign merged_out.valid           = out_valid_reg;
    assign merged_out.merged_distance = out_d_reg;
    assign merged_out.merged_angle    = out_a_reg;
    assign merged_out.group_size      = out_size_reg;
    assign merged_out.end_of_list     = out_last_reg;
    assign merged_out.lines_dropped   = out_drop_reg;

endmodule
